FILE: rtl/cld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types, codes and character constants of the deframer.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int unsigned LEN_W    = 24;
    localparam int unsigned ACC_W    = LEN_W + 1;
    localparam int unsigned KEY_LEN  = 15;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 24'd10485760;
    localparam logic [ACC_W-1:0] ACC_CAP          = 25'd16777216;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_NO_KEY  = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        NP_BEFORE = 2'd0,
        NP_DIGITS = 2'd1,
        NP_DONE   = 2'd2
    } num_phase_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic       last_byte;
    } result_t;

    // Characters of the key "Content-Length:"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the blank line CR LF CR LF
    function automatic logic [7:0] end_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_CR;
            2'd1:    c = CHAR_LF;
            2'd2:    c = CHAR_CR;
            default: c = CHAR_LF;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/cld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_front
// Header scanner and body counter; classifies each request and issues at
// most one result into the queue.
// ----------------------------------------------------------------------------
module cld_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cld_pkg::LEN_W-1:0] cfg_data,
    input  logic                      accept,
    input  logic [7:0]                data_byte,
    output logic                      push,
    output cld_pkg::result_t          push_data
);

    logic [cld_pkg::LEN_W-1:0] max_length_reg;
    logic                      in_payload_reg, in_payload_next;
    logic [1:0]                end_cnt_reg, end_cnt_next;
    logic [3:0]                key_cnt_reg, key_cnt_next;
    logic                      key_seen_reg, key_seen_next;
    cld_pkg::num_phase_t       phase_reg, phase_next;
    logic                      negative_reg, negative_next;
    logic [cld_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [cld_pkg::LEN_W-1:0] remain_reg, remain_next;

    logic                      is_digit;
    logic [3:0]                digit_val;
    logic [cld_pkg::ACC_W+3:0] product;
    logic [cld_pkg::ACC_W-1:0] acc_step;
    logic [2:0]                end_cnt_inc;

    assign is_digit  = (data_byte >= cld_pkg::CHAR_ZERO) && (data_byte <= cld_pkg::CHAR_NINE);
    assign digit_val = 4'(data_byte - cld_pkg::CHAR_ZERO);
    // acc * 10 + digit as two shifts and adds
    assign product   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                       + {{(cld_pkg::ACC_W){1'b0}}, digit_val};
    assign acc_step  = (product > {4'h0, cld_pkg::ACC_CAP}) ? cld_pkg::ACC_CAP
                                                           : product[cld_pkg::ACC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= cld_pkg::MAX_LENGTH_RESET;
            in_payload_reg <= 1'b0;
            end_cnt_reg    <= '0;
            key_cnt_reg    <= '0;
            key_seen_reg   <= 1'b0;
            phase_reg      <= cld_pkg::NP_BEFORE;
            negative_reg   <= 1'b0;
            acc_reg        <= '0;
            remain_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_length_reg <= cfg_data;
            end
            in_payload_reg <= in_payload_next;
            end_cnt_reg    <= end_cnt_next;
            key_cnt_reg    <= key_cnt_next;
            key_seen_reg   <= key_seen_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            acc_reg        <= acc_next;
            remain_reg     <= remain_next;
        end
    end

    always_comb
    begin
        in_payload_next = in_payload_reg;
        end_cnt_next    = end_cnt_reg;
        key_cnt_next    = key_cnt_reg;
        key_seen_next   = key_seen_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        end_cnt_inc     = '0;
        push            = 1'b0;
        push_data       = '{status: cld_pkg::ST_PAYLOAD, payload_byte: 8'h00, last_byte: 1'b0};

        if (accept)
        begin
            if (in_payload_reg)
            begin
                remain_next = remain_reg - 1'b1;
                push        = 1'b1;
                push_data   = '{status: cld_pkg::ST_PAYLOAD, payload_byte: data_byte,
                                last_byte: (remain_next == '0)};
                if (remain_next == '0)
                begin
                    in_payload_next = 1'b0;
                end
            end
            else
            begin
                if (key_seen_reg)
                begin
                    case (phase_reg)
                        cld_pkg::NP_BEFORE:
                        begin
                            if (data_byte inside {cld_pkg::CHAR_SPACE, cld_pkg::CHAR_TAB})
                            begin
                                phase_next = cld_pkg::NP_BEFORE;
                            end
                            else if (data_byte inside {cld_pkg::CHAR_PLUS, cld_pkg::CHAR_MINUS})
                            begin
                                negative_next = (data_byte == cld_pkg::CHAR_MINUS);
                                phase_next    = cld_pkg::NP_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                phase_next = cld_pkg::NP_DIGITS;
                                acc_next   = acc_step;
                            end
                            else
                            begin
                                phase_next = cld_pkg::NP_DONE;
                            end
                        end
                        cld_pkg::NP_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_step;
                            end
                            else
                            begin
                                phase_next = cld_pkg::NP_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = cld_pkg::NP_DONE;
                        end
                    endcase
                end
                else
                begin
                    if (data_byte == cld_pkg::key_char(key_cnt_reg))
                    begin
                        key_cnt_next = key_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        key_cnt_next = (data_byte == cld_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                    if (key_cnt_next == 4'(cld_pkg::KEY_LEN))
                    begin
                        key_seen_next = 1'b1;
                        key_cnt_next  = '0;
                    end
                end

                if (data_byte == cld_pkg::end_char(end_cnt_reg))
                begin
                    end_cnt_inc = {1'b0, end_cnt_reg} + 3'd1;
                end
                else
                begin
                    end_cnt_inc = (data_byte == cld_pkg::CHAR_CR) ? 3'd1 : 3'd0;
                end
                end_cnt_next = end_cnt_inc[1:0];

                // Header complete: decide between body and an error result
                if (end_cnt_inc[2])
                begin
                    if (!key_seen_next)
                    begin
                        push      = 1'b1;
                        push_data = '{status: cld_pkg::ST_NO_KEY, payload_byte: 8'h00,
                                      last_byte: 1'b1};
                    end
                    else if (negative_next || (acc_next == '0)
                             || (acc_next > {1'b0, max_length_reg}))
                    begin
                        push      = 1'b1;
                        push_data = '{status: cld_pkg::ST_RANGE, payload_byte: 8'h00,
                                      last_byte: 1'b1};
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                        remain_next     = acc_next[cld_pkg::LEN_W-1:0];
                    end
                    end_cnt_next  = '0;
                    key_cnt_next  = '0;
                    key_seen_next = 1'b0;
                    phase_next    = cld_pkg::NP_BEFORE;
                    negative_next = 1'b0;
                    acc_next      = '0;
                end
            end
        end
    end

endmodule

FILE: rtl/cld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_queue
// Short result queue between the scanner and the output stage.
// ----------------------------------------------------------------------------
module cld_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cld_pkg::result_t push_data,
    input  logic             pop,
    output cld_pkg::result_t head_data,
    output logic             not_empty,
    output logic             full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cld_pkg::result_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_data = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/cld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_back
// Output register: take results from the queue and hold them for the sink.
// ----------------------------------------------------------------------------
module cld_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  cld_pkg::result_t head_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output cld_pkg::result_t out_data
);

    logic             valid_reg;
    cld_pkg::result_t data_reg;

    // Load when the register is empty or its request leaves this cycle
    assign pop       = head_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head_data;
        end
    end

endmodule

FILE: rtl/content_length_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_length_deframer_unit
// Content-Length deframer: scan a header for the length key and blank line,
// then pass that many body bytes on, or report one error result.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | in_valid / in_ready  | data_byte[7:0]
//   output   | out_valid / out_ready| status[1:0], payload_byte[7:0],
//            |                      | last_byte
//   config   | cfg_we (no wait)     | cfg_data[23:0] -> max_length
//
// One input request a cycle while the result queue is not full: the scanner
// updates its state on every byte it takes. A result is written into the
// queue at the edge that takes its byte, then passes the output register.
// Reset clears the header state, the queue and the output register;
// max_length returns to 10485760.
// in_ready drops only when the result queue is full, so a stalled sink
// holds the scanner once QUEUE_DEPTH results wait behind the output register.
// ----------------------------------------------------------------------------
module content_length_deframer_unit
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  payload_byte,
    output logic        last_byte
);

    logic             accept;
    logic             push;
    cld_pkg::result_t push_data;
    logic             pop;
    cld_pkg::result_t head_data;
    logic             head_valid;
    logic             queue_full;
    cld_pkg::result_t out_data;

    // Take a byte whenever the queue can absorb any result it causes
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    cld_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .push      (push),
        .push_data (push_data)
    );

    cld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    cld_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Break the result out onto its field ports
    assign status       = out_data.status;
    assign payload_byte = out_data.payload_byte;
    assign last_byte    = out_data.last_byte;

endmodule
